// ----- hw/rtl/siw_pkg.sv -----
// session idle watchdog package: word types, field widths and codes
// shared by siw_core and session_idle_watchdog_top; depends on nothing
package siw_pkg;

  localparam int Channels   = 16;
  localparam int FuncW      = 2;
  localparam int ChanIdxW   = 4;
  localparam int MsgW       = 2;
  localparam int RemainW    = 5;
  localparam int TargetsW   = 16;
  localparam int PhaseW     = 3;
  localparam int CountW     = 5;
  localparam int TimeoutW   = 16;
  localparam int CloseW     = 4;

  localparam logic [TimeoutW-1:0] LeadTimeout = TimeoutW'(30);
  localparam logic [RemainW-1:0]  LeadSeconds = RemainW'(30);
  localparam logic [CloseW-1:0]   CloseDelay  = CloseW'(10);

  // event codes
  localparam logic [FuncW-1:0] FuncTick     = 2'd0;
  localparam logic [FuncW-1:0] FuncRegister = 2'd1;
  localparam logic [FuncW-1:0] FuncRelease  = 2'd2;
  localparam logic [FuncW-1:0] FuncActivity = 2'd3;

  // result message codes
  localparam logic [MsgW-1:0] MsgNone      = 2'd0;
  localparam logic [MsgW-1:0] MsgCountdown = 2'd1;
  localparam logic [MsgW-1:0] MsgLogout    = 2'd2;
  localparam logic [MsgW-1:0] MsgClose     = 2'd3;

  typedef struct packed {
    logic [FuncW-1:0]    func;
    logic [ChanIdxW-1:0] channel;
  } evt_word_t;

  typedef struct packed {
    logic [MsgW-1:0]     message;
    logic [RemainW-1:0]  remaining;
    logic [TargetsW-1:0] targets;
    logic [PhaseW-1:0]   phase_now;
    logic [CountW-1:0]   channel_total;
    logic                channel_present;
  } res_word_t;

endpackage

// ----- hw/rtl/session_idle_watchdog_top.sv -----
// session idle watchdog top level: timeout register, core and result register
// depends on siw_pkg and siw_core
//
// Every event word (tick, channel register, channel release, activity)
// yields exactly one result word. The core updates phase, timers and
// channel bitmap as the word is accepted and the result lands in an
// output register, valid in the following cycle, so one event per cycle
// is sustained while the result side keeps up; evt_ready drops only
// while a result waits on res_ready. session_timeout is written through
// cfg_we/cfg_data and is sampled when the active phase is armed; write
// it only while no event is in flight.
module session_idle_watchdog_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         evt_valid,
  output logic                         evt_ready,
  input  siw_pkg::evt_word_t           evt,
  output logic                         res_valid,
  input  logic                         res_ready,
  output siw_pkg::res_word_t           res,
  input  logic                         cfg_we,
  input  logic [siw_pkg::TimeoutW-1:0] cfg_data
);
  import siw_pkg::*;

  logic [TimeoutW-1:0] session_timeout;
  logic                take;
  res_word_t           res_calc;

  assign evt_ready = !res_valid || res_ready;
  assign take      = evt_valid && evt_ready;

  siw_core u_core (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .timeout (session_timeout),
    .evt     (evt),
    .res     (res_calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      session_timeout <= '0;
    end else if (cfg_we) begin
      session_timeout <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (evt_ready) begin
      res_valid <= evt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_calc;
    end
  end

endmodule

// ----- hw/rtl/siw_core.sv -----
// session idle watchdog core: phase machine, timers and channel bitmap
// depends on siw_pkg; result is combinational from state and event word
module siw_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [siw_pkg::TimeoutW-1:0]  timeout,
  input  siw_pkg::evt_word_t            evt,
  output siw_pkg::res_word_t            res
);
  import siw_pkg::*;

  typedef enum logic [PhaseW-1:0] {
    PH_IDLE      = 3'd0,
    PH_ACTIVE    = 3'd1,
    PH_COUNTDOWN = 3'd2,
    PH_LOGOUT    = 3'd3,
    PH_CLOSED    = 3'd4
  } phase_t;

  phase_t                phase, phase_next;
  logic [TimeoutW-1:0]   active_left, active_left_next;
  logic [RemainW-1:0]    seconds_left, seconds_left_next;
  logic [CloseW-1:0]     close_left, close_left_next;
  logic [Channels-1:0]   chan_set, chan_set_next;
  logic [CountW-1:0]     chan_count, chan_count_next;

  logic                  chan_ok;
  logic [Channels-1:0]   chan_bit;
  logic                  armable;
  logic [TimeoutW-1:0]   active_dec;
  logic [CloseW-1:0]     close_dec;
  logic [MsgW-1:0]       msg;
  logic [RemainW-1:0]    rem;

  always_comb begin
    chan_ok  = (32'(evt.channel) < Channels);
    chan_bit = chan_ok ? (Channels'(1) << evt.channel) : '0;
    armable  = timeout > LeadTimeout;
    active_dec = (active_left != '0) ? active_left - TimeoutW'(1) : active_left;
    close_dec  = (close_left != '0) ? close_left - CloseW'(1) : close_left;

    phase_next        = phase;
    active_left_next  = active_left;
    seconds_left_next = seconds_left;
    close_left_next   = close_left;
    chan_set_next     = chan_set;
    chan_count_next   = chan_count;
    msg               = MsgNone;
    rem               = '0;

    unique case (evt.func)
      FuncTick: begin
        case (phase)
          PH_ACTIVE: begin
            active_left_next = active_dec;
            if (active_dec == '0) begin
              phase_next        = PH_COUNTDOWN;
              seconds_left_next = LeadSeconds;
            end
          end
          PH_COUNTDOWN: begin
            if (seconds_left != '0) begin
              msg               = MsgCountdown;
              rem               = seconds_left;
              seconds_left_next = seconds_left - RemainW'(1);
            end else begin
              msg             = MsgLogout;
              phase_next      = PH_LOGOUT;
              close_left_next = CloseDelay;
            end
          end
          PH_LOGOUT: begin
            close_left_next = close_dec;
            if (close_dec == '0) begin
              msg        = MsgClose;
              phase_next = PH_CLOSED;
            end
          end
          default: ;
        endcase
      end
      FuncRegister: begin
        if (chan_ok) begin
          if ((chan_set & chan_bit) == '0) begin
            chan_set_next   = chan_set | chan_bit;
            chan_count_next = chan_count + CountW'(1);
          end
          // arm only on the first channel of an idle session
          if (chan_count == '0 && armable && phase == PH_IDLE) begin
            phase_next        = PH_ACTIVE;
            active_left_next  = timeout - LeadTimeout;
            seconds_left_next = '0;
            close_left_next   = '0;
          end
        end
      end
      FuncRelease: begin
        if ((chan_set & chan_bit) != '0) begin
          chan_set_next   = chan_set & ~chan_bit;
          chan_count_next = chan_count - CountW'(1);
          // countdown, logout and close keep running with no targets
          if (chan_count_next == '0 && phase == PH_ACTIVE) begin
            phase_next       = PH_IDLE;
            active_left_next = '0;
          end
        end
      end
      FuncActivity: begin
        if (chan_count != '0 && armable && phase != PH_CLOSED) begin
          phase_next        = PH_ACTIVE;
          active_left_next  = timeout - LeadTimeout;
          seconds_left_next = '0;
          close_left_next   = '0;
        end
      end
      default: ;
    endcase

    res.message         = msg;
    res.remaining       = rem;
    res.targets         = TargetsW'(chan_set_next);
    res.phase_now       = phase_next;
    res.channel_total   = chan_count_next;
    res.channel_present = (chan_set_next & chan_bit) != '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      active_left  <= '0;
      seconds_left <= '0;
      close_left   <= '0;
      chan_set     <= '0;
      chan_count   <= '0;
    end else if (take) begin
      phase        <= phase_next;
      active_left  <= active_left_next;
      seconds_left <= seconds_left_next;
      close_left   <= close_left_next;
      chan_set     <= chan_set_next;
      chan_count   <= chan_count_next;
    end
  end

endmodule
